// File: rtl/circle_ring_rasterizer_defines.svh
// Assertion shorthands for the rasteriser checker; clk and rst_n are taken from the
// scope of use.
`ifndef CIRCLE_RING_RASTERIZER_DEFINES_SVH
`define CIRCLE_RING_RASTERIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle ring rasteriser check failed");

// Consequent checked in the cycle after the antecedent.
`define CRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle ring rasteriser check failed");

`endif

// File: rtl/cra_pkg.sv
package cra_pkg;

    localparam int POINTS_PER_STEP = 8;
    localparam int PT_IDX_W        = $clog2(POINTS_PER_STEP);

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

// File: rtl/cra_queue.sv
module cra_queue #(
    parameter int WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head,
    output cra_pkg::queue_flags_t flags
);
    import cra_pkg::*;

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [WIDTH-1:0] head_reg;
    logic [WIDTH-1:0] tail_reg;

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Two ordered slots: the head moves up from the tail on a pop.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && count_reg == 2'd1)
            begin
                head_reg <= push_data;
            end
            else
            begin
                head_reg <= tail_reg;
            end
            if (push && count_reg == 2'd2)
            begin
                tail_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                tail_reg <= push_data;
            end
        end
    end

    assign head        = head_reg;
    assign flags.full  = (count_reg == 2'd2);
    assign flags.empty = (count_reg == 2'd0);

endmodule

// File: rtl/cra_front.sv
module cra_front #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 13,
    parameter int AB_W        = RADIUS_BITS + 2,
    parameter int ENTRY_W     = 2 * COORD_BITS + 2 * AB_W + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  cra_pkg::cmd_t                command,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic [RADIUS_BITS-1:0]       radius,
    input  logic [RADIUS_BITS:0]         ring_width,
    output logic                         push,
    output logic [ENTRY_W-1:0]           push_data
);
    import cra_pkg::*;

    localparam int D_W = RADIUS_BITS + 4;

    logic                         busy_reg;
    logic                         busy_next;
    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic [RADIUS_BITS-1:0]       floor_reg;
    logic [RADIUS_BITS-1:0]       floor_next;
    logic [RADIUS_BITS-1:0]       ring_reg;
    logic [RADIUS_BITS-1:0]       ring_next;
    logic signed [AB_W-1:0]       a_reg;
    logic signed [AB_W-1:0]       a_next;
    logic signed [AB_W-1:0]       b_reg;
    logic signed [AB_W-1:0]       b_next;
    logic signed [D_W-1:0]        d_reg;
    logic signed [D_W-1:0]        d_next;

    logic signed [AB_W-1:0]       floor_calc;
    logic signed [D_W-1:0]        a_ext;
    logic signed [D_W-1:0]        b_ext;
    logic signed [D_W-1:0]        r_ext;
    logic signed [D_W-1:0]        step_d;
    logic signed [AB_W-1:0]       step_a;
    logic signed [AB_W-1:0]       step_b;
    logic                         final_pt;

    assign floor_calc = $signed({2'b00, radius}) - $signed({1'b0, ring_width})
                        + AB_W'(1);
    assign a_ext      = D_W'(a_reg);
    assign b_ext      = D_W'(b_reg);
    assign r_ext      = D_W'($signed({1'b0, ring_reg}));

    // Three-way midpoint decision
    always_comb
    begin
        step_a = a_reg;
        step_b = b_reg;
        step_d = d_reg;
        priority if (d_reg >= (a_ext <<< 1))
        begin
            step_d = d_reg - (a_ext <<< 1) - D_W'(1);
            step_a = a_reg + AB_W'(1);
        end
        else if (d_reg < ((r_ext - b_ext) <<< 1))
        begin
            step_d = d_reg + (b_ext <<< 1) - D_W'(1);
            step_b = b_reg - AB_W'(1);
        end
        else
        begin
            step_d = d_reg + ((b_ext - a_ext - D_W'(1)) <<< 1);
            step_b = b_reg - AB_W'(1);
            step_a = a_reg + AB_W'(1);
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        floor_next = floor_reg;
        ring_next  = ring_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        final_pt   = 1'b0;
        push       = 1'b0;
        if (accept)
        begin
            unique case (command)
                CMD_START:
                begin
                    busy_next  = (ring_width != '0);
                    floor_next = floor_calc[AB_W-1] ? '0 : floor_calc[RADIUS_BITS-1:0];
                    ring_next  = radius;
                    a_next     = '0;
                    b_next     = AB_W'($signed({1'b0, radius}));
                    d_next     = D_W'($signed({1'b0, radius})) - D_W'(1);
                end
                CMD_STEP:
                begin
                    if (busy_reg)
                    begin
                        push   = 1'b1;
                        a_next = step_a;
                        b_next = step_b;
                        d_next = step_d;
                        if (step_b < step_a)
                        begin
                            if (ring_reg > floor_reg)
                            begin
                                // Advance inward to the next outline
                                ring_next = ring_reg - RADIUS_BITS'(1);
                                a_next    = '0;
                                b_next    = AB_W'($signed({1'b0, ring_next}));
                                d_next    = D_W'($signed({1'b0, ring_next})) - D_W'(1);
                            end
                            else
                            begin
                                busy_next = 1'b0;
                                final_pt  = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_START)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
        end
        floor_reg <= floor_next;
        ring_reg  <= ring_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        d_reg     <= d_next;
    end

    // Points are formed from the offsets before the update
    assign push_data = {final_pt, b_reg, a_reg, cy_reg, cx_reg};

endmodule

// File: rtl/cra_back.sv
module cra_back #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 13,
    parameter int AB_W        = RADIUS_BITS + 2,
    parameter int ENTRY_W     = 2 * COORD_BITS + 2 * AB_W + 1,
    parameter int PIX_W       = COORD_BITS + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ENTRY_W-1:0]    head,
    input  cra_pkg::queue_flags_t flags,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_x,
    output logic [PIX_W-1:0]      pixel_y,
    output logic                  last_of_step,
    output logic                  last_of_circle
);
    import cra_pkg::*;

    localparam int SUM_W = ((COORD_BITS > AB_W) ? COORD_BITS : AB_W) + 1;
    localparam logic [PT_IDX_W-1:0] LAST_IDX = PT_IDX_W'(POINTS_PER_STEP - 1);

    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [AB_W-1:0]       a;
    logic signed [AB_W-1:0]       b;
    logic                         final_pt;

    logic [PT_IDX_W-1:0]          idx_reg;
    logic [PT_IDX_W-1:0]          idx_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         load;
    logic                         emit;
    logic signed [SUM_W-1:0]      sel_x;
    logic signed [SUM_W-1:0]      sel_y;
    logic signed [SUM_W-1:0]      sum_x;
    logic signed [SUM_W-1:0]      sum_y;

    assign {final_pt, b, a, cy, cx} = head;

    assign load = !valid_reg || out_ready;
    assign emit = load && !flags.empty;
    assign pop  = emit && (idx_reg == LAST_IDX);

    // Index bit 2 swaps the offsets, bit 1 negates x, bit 0 negates y
    always_comb
    begin
        sel_x = idx_reg[2] ? SUM_W'(b) : SUM_W'(a);
        sel_y = idx_reg[2] ? SUM_W'(a) : SUM_W'(b);
        sum_x = idx_reg[1] ? SUM_W'(cx) - sel_x : SUM_W'(cx) + sel_x;
        sum_y = idx_reg[0] ? SUM_W'(cy) - sel_y : SUM_W'(cy) + sel_y;
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            idx_next   = idx_reg + PT_IDX_W'(1);
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x        <= sum_x[PIX_W-1:0];
            pixel_y        <= sum_y[PIX_W-1:0];
            last_of_step   <= (idx_reg == LAST_IDX);
            last_of_circle <= final_pt && (idx_reg == LAST_IDX);
        end
    end

    assign out_valid = valid_reg;

endmodule

// File: rtl/circle_ring_rasterizer.sv
// Channel  Dir  tdata (low bit up)                            tlast         tuser
// s_*      in   center_x, center_y, radius, ring_width        -             command
// m_*      out  pixel_x, pixel_y                              last_of_step  last_of_circle
//
// A start or step item is taken when s_tvalid and s_tready are both high; a step that draws queues one entry.
// Each step then yields eight points, one per cycle from the output register while m_tready is high,
// so the point emitter sets the pace of a stream of steps.
// The two-entry queue holds the step whose points are draining and one more step taken ahead.
// rst_n clears the drawing state, the queue and the output register at once.
// A stall on m_tready holds the current point and fills the queue, then drops s_tready.
module circle_ring_rasterizer #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 13,
    localparam int IN_TDATA_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // center_x, center_y, radius, ring_width
    input  logic                   s_tuser,  // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // pixel_x, pixel_y
    output logic                   m_tlast,  // last_of_step
    output logic                   m_tuser   // last_of_circle
);
    import cra_pkg::*;

    localparam int AB_W    = RADIUS_BITS + 2;
    localparam int ENTRY_W = 2 * COORD_BITS + 2 * AB_W + 1;
    localparam int PIX_W   = COORD_BITS + 1;
    localparam int CY_LO   = COORD_BITS;
    localparam int RAD_LO  = 2 * COORD_BITS;
    localparam int W_LO    = 2 * COORD_BITS + RADIUS_BITS;

    logic                         accept;
    cmd_t                         command;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [RADIUS_BITS-1:0]       radius;
    logic [RADIUS_BITS:0]         ring_width;
    logic                         push;
    logic [ENTRY_W-1:0]           push_data;
    logic                         pop;
    logic [ENTRY_W-1:0]           head;
    queue_flags_t                 flags;
    logic [PIX_W-1:0]             pixel_x;
    logic [PIX_W-1:0]             pixel_y;

    assign s_tready   = !flags.full;
    assign accept     = s_tvalid && s_tready;
    assign command    = cmd_t'(s_tuser);
    assign center_x   = $signed(s_tdata[COORD_BITS-1:0]);
    assign center_y   = $signed(s_tdata[CY_LO+COORD_BITS-1:CY_LO]);
    assign radius     = s_tdata[RAD_LO+RADIUS_BITS-1:RAD_LO];
    assign ring_width = s_tdata[W_LO+RADIUS_BITS:W_LO];

    cra_front #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS),
        .AB_W       (AB_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .ring_width(ring_width),
        .push      (push),
        .push_data (push_data)
    );

    cra_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .flags    (flags)
    );

    cra_back #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS),
        .AB_W       (AB_W),
        .ENTRY_W    (ENTRY_W),
        .PIX_W      (PIX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .flags         (flags),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_of_step  (m_tlast),
        .last_of_circle(m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'({pixel_y, pixel_x});

endmodule

// File: rtl/cra_checker.sv
`include "circle_ring_rasterizer_defines.svh"

module cra_checker #(
    parameter int COORD_BITS = 13,
    localparam int OUT_TDATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   m_tuser
);

    // The end of the drawing only falls on the eighth point of a step
    `CRA_ASSERT_NOW(a_final_on_last, m_tvalid && m_tuser, m_tlast)

    // The eight points of one step leave without a gap
    `CRA_ASSERT_NEXT(a_step_unbroken, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // Hold a stalled point
    `CRA_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

bind circle_ring_rasterizer cra_checker #(.COORD_BITS(COORD_BITS)) u_cra_checker (.*);
